[rtl/core/buddy_page_allocator_top_macros.svh]
// assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator assertion failed");
`define BPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator assertion failed");
`else
`define BPA_ASSERT_IMP(lbl, ante, cons)
`define BPA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/core/bpa_pkg.sv]
package bpa_pkg;

    localparam int CNT_W      = 11;
    localparam int OFS_W      = 10;
    localparam int TOT_W      = 11;
    localparam int ACT_W      = 2;
    localparam int ST_W       = 2;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 24;

    localparam logic [CNT_W-1:0] MANAGED_RESET = 11'd1024;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_REBUILD = 2'd2
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD      = 2'd2
    } t_status;

    typedef enum logic {
        ALU_MERGE = 1'b0,
        ALU_FILL  = 1'b1
    } t_alu_op;

endpackage

[rtl/core/buddy_page_allocator_top.sv]
// allocate: one tree level per cycle down and up
// free: one level per cycle on the way up
// rebuild: one node write per cycle; rejected requests skip the tree walk
// one node read and one node write per cycle set the pace; one transaction in flight at a time
// reset (synchronous, active low) clears control, free total and sets managed_pages to 1024
// tree contents are undefined after reset until the first rebuild
`include "buddy_page_allocator_top_macros.svh"

module buddy_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int TREE_PAGES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CNT_W-1:0]    i_cfg_wdata,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // page_count [10:0], page_offset [20:11]
    input  logic [ACT_W-1:0]    i_s_tuser,  // action [1:0]
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // block_offset [9:0], free page total [20:10]
    output logic [ST_W-1:0]     o_m_tuser   // status [1:0]
);

    localparam int LOG    = $clog2(TREE_PAGES);
    localparam int AW     = LOG + 1;
    localparam int VAL_W  = LOG + 1;
    localparam int LG_W   = $clog2(LOG + 1);
    localparam int DEPTH  = 2 * TREE_PAGES - 1;
    localparam int CMP_W  = (LOG + 2 > 12) ? LOG + 2 : 12;

    localparam logic [CMP_W-1:0] TP_C      = CMP_W'(TREE_PAGES);
    localparam logic [VAL_W-1:0] TP_V      = VAL_W'(TREE_PAGES);
    localparam logic [AW-1:0]    TP_N      = AW'(TREE_PAGES);
    localparam logic [AW-1:0]    NODE_LAST = AW'(2 * TREE_PAGES - 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_DOWN,
        S_CHECK,
        S_UP,
        S_FILL,
        S_EMIT
    } t_state;

    function automatic logic [3:0] f_ceil_log2(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] m;
        logic [3:0]       r;
        m = c - CNT_W'(1);
        r = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (m[i]) begin
                r = 4'(i + 1);
            end
        end
        return r;
    endfunction

    t_state             r_state, n_state;
    logic [AW-1:0]      r_node, n_node;
    logic [VAL_W-1:0]   r_span, n_span;
    logic [VAL_W-1:0]   r_len, n_len;
    logic [VAL_W-1:0]   r_cur, n_cur;
    logic [VAL_W-1:0]   r_start, n_start;
    logic [TOT_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_managed;
    t_status            r_status, n_status;
    logic [OFS_W-1:0]   r_offset, n_offset;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [OFS_W-1:0]   r_out_offset, n_out_offset;
    logic [TOT_W-1:0]   r_out_total, n_out_total;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VAL_W-1:0]   mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VAL_W-1:0]   mem_rdata;

    t_alu_op            alu_op;
    logic [VAL_W-1:0]   alu_a;
    logic [VAL_W-1:0]   alu_b;
    logic [VAL_W-1:0]   alu_len;
    logic [VAL_W-1:0]   alu_val;

    logic               s_accept;
    logic [CNT_W-1:0]   in_count;
    logic [OFS_W-1:0]   in_offset;
    logic               count_bad;
    logic [LG_W-1:0]    in_lg;
    logic [VAL_W-1:0]   in_len;
    logic               free_bad;
    logic [AW-1:0]      free_node;
    logic [VAL_W-1:0]   m_eff;
    logic               emit_load;

    logic [AW-1:0]      down_node;
    logic [VAL_W-1:0]   down_start;
    logic [AW-1:0]      node_sib;
    logic [AW-1:0]      node_par;
    logic [AW-1:0]      par_sib;
    logic [VAL_W-1:0]   fill_end;

    bpa_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bpa_node_alu #(
        .VAL_W (VAL_W)
    ) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_len (alu_len),
        .o_val (alu_val)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign in_count   = i_s_tdata[CNT_W-1:0];
    assign in_offset  = i_s_tdata[CNT_W+OFS_W-1:CNT_W];

    assign count_bad = (in_count == '0) || (CMP_W'(in_count) > TP_C);
    assign in_lg     = LG_W'(f_ceil_log2(in_count));
    assign in_len    = VAL_W'(1) << in_lg;
    assign free_bad  = ((in_offset & ~({OFS_W{1'b1}} << in_lg)) != '0)
                    || (CMP_W'(in_offset) + CMP_W'(in_len) > TP_C);
    assign free_node = (TP_N >> in_lg) - AW'(1) + AW'(in_offset >> in_lg);

    assign m_eff = (CMP_W'(r_managed) > TP_C) ? TP_V : VAL_W'(r_managed);

    assign down_node  = (mem_rdata >= r_len) ? (r_node << 1) + AW'(1)
                                             : (r_node << 1) + AW'(2);
    assign down_start = (mem_rdata >= r_len) ? r_start : r_start + r_span;
    assign node_sib   = r_node[0] ? r_node + AW'(1) : r_node - AW'(1);
    assign node_par   = (r_node - AW'(1)) >> 1;
    assign par_sib    = node_par[0] ? node_par + AW'(1) : node_par - AW'(1);
    assign fill_end   = r_start + r_span;

    assign alu_op  = (r_state == S_FILL) ? ALU_FILL : ALU_MERGE;
    assign alu_a   = (r_state == S_FILL) ? m_eff : r_cur;
    assign alu_b   = (r_state == S_FILL) ? r_start : mem_rdata;
    assign alu_len = (r_state == S_FILL) ? r_span : r_len;

    assign emit_load = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state      = r_state;
        n_node       = r_node;
        n_span       = r_span;
        n_len        = r_len;
        n_cur        = r_cur;
        n_start      = r_start;
        n_total      = r_total;
        n_status     = r_status;
        n_offset     = r_offset;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_offset = r_out_offset;
        n_out_total  = r_out_total;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_status = ST_OK;
                    n_offset = '0;
                    n_len    = in_len;
                    n_cur    = in_len;
                    case (t_action'(i_s_tuser))
                        ACT_ALLOC: begin
                            if (count_bad) begin
                                n_status = ST_BAD;
                                n_state  = S_EMIT;
                            end else begin
                                mem_raddr = '0;
                                n_state   = S_ROOT;
                            end
                        end
                        ACT_FREE: begin
                            if (count_bad || free_bad) begin
                                n_status = ST_BAD;
                                n_state  = S_EMIT;
                            end else begin
                                mem_raddr = free_node;
                                n_node    = free_node;
                                n_state   = S_CHECK;
                            end
                        end
                        ACT_REBUILD: begin
                            n_node  = '0;
                            n_start = '0;
                            n_span  = TP_V;
                            n_state = S_FILL;
                        end
                        default: begin
                            n_status = ST_BAD;
                            n_state  = S_EMIT;
                        end
                    endcase
                end
            end
            S_ROOT: begin
                if (mem_rdata < r_len) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_EMIT;
                end else if (r_len == TP_V) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = '0;
                    n_total   = r_total - TOT_W'(r_len);
                    n_state   = S_EMIT;
                end else begin
                    mem_raddr = AW'(1);
                    n_node    = '0;
                    n_start   = '0;
                    n_span    = TP_V >> 1;
                    n_state   = S_DOWN;
                end
            end
            S_DOWN: begin
                n_node  = down_node;
                n_start = down_start;
                if (r_span == r_len) begin
                    mem_we    = 1'b1;
                    mem_waddr = down_node;
                    mem_wdata = '0;
                    mem_raddr = down_node[0] ? down_node + AW'(1) : down_node - AW'(1);
                    n_cur     = '0;
                    n_total   = r_total - TOT_W'(r_len);
                    n_offset  = OFS_W'(down_start);
                    n_state   = S_UP;
                end else begin
                    mem_raddr = (down_node << 1) + AW'(1);
                    n_span    = r_span >> 1;
                end
            end
            S_CHECK: begin
                if (mem_rdata != '0) begin
                    n_status = ST_BAD;
                    n_state  = S_EMIT;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_node;
                    mem_wdata = r_len;
                    n_total   = r_total + TOT_W'(r_len);
                    if (r_node == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        mem_raddr = node_sib;
                        n_state   = S_UP;
                    end
                end
            end
            S_UP: begin
                mem_we    = 1'b1;
                mem_waddr = node_par;
                mem_wdata = alu_val;
                mem_raddr = par_sib;
                n_node    = node_par;
                n_cur     = alu_val;
                n_len     = r_len << 1;
                if (node_par == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_node;
                mem_wdata = alu_val;
                n_node    = r_node + AW'(1);
                if (fill_end == TP_V) begin
                    n_start = '0;
                    n_span  = r_span >> 1;
                    if (r_span == VAL_W'(1)) begin
                        n_total = TOT_W'(m_eff);
                        n_state = S_EMIT;
                    end
                end else begin
                    n_start = fill_end;
                end
            end
            S_EMIT: begin
                if (emit_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_offset = r_offset;
                    n_out_total  = r_total;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_managed   <= MANAGED_RESET;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_total      <= n_total;
            if (i_cfg_we) begin
                r_managed <= i_cfg_wdata;
            end
            r_node       <= n_node;
            r_span       <= n_span;
            r_len        <= n_len;
            r_cur        <= n_cur;
            r_start      <= n_start;
            r_status     <= n_status;
            r_offset     <= n_offset;
            r_out_status <= n_out_status;
            r_out_offset <= n_out_offset;
            r_out_total  <= n_out_total;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{(M_DATA_W - OFS_W - TOT_W){1'b0}}, r_out_total, r_out_offset};

    `BPA_ASSERT_NXT(a_busy_after_accept, s_accept, !o_s_tready)
    `BPA_ASSERT_IMP(a_write_in_tree, mem_we, mem_waddr <= NODE_LAST)
    `BPA_ASSERT_IMP(a_descent_span, r_state == S_DOWN, r_span >= r_len)
    `BPA_ASSERT_NXT(a_emit_loads_output, emit_load, r_out_valid && r_state == S_IDLE)

endmodule

[rtl/core/bpa_ram.sv]
module bpa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 2047
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bpa_node_alu.sv]
module bpa_node_alu
    import bpa_pkg::*;
#(
    parameter int VAL_W = 11
) (
    input  t_alu_op          i_op,
    input  logic [VAL_W-1:0] i_a,
    input  logic [VAL_W-1:0] i_b,
    input  logic [VAL_W-1:0] i_len,
    output logic [VAL_W-1:0] o_val
);

    function automatic logic [VAL_W-1:0] f_pow2_floor(input logic [VAL_W-1:0] k);
        logic [VAL_W-1:0] r;
        r = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (k[i]) begin
                r    = '0;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    logic [VAL_W-1:0] end_page;

    assign end_page = i_b + i_len;

    always_comb begin
        case (i_op)
            ALU_MERGE: begin
                // both buddies wholly free merge into the parent block
                if (i_a == i_len && i_b == i_len) begin
                    o_val = i_len << 1;
                end else begin
                    o_val = (i_a > i_b) ? i_a : i_b;
                end
            end
            ALU_FILL: begin
                // a = usable pages, b = block start, len = block size
                if (i_a >= end_page) begin
                    o_val = i_len;
                end else if (i_a <= i_b) begin
                    o_val = '0;
                end else begin
                    o_val = f_pow2_floor(i_a - i_b);
                end
            end
            default: begin
                o_val = '0;
            end
        endcase
    end

endmodule
